// ===== rtl/clam_pkg.sv =====
// Shared constants, codes and helper functions for the command line assembler.
// No dependencies; the top level and the testbench import it.
package clam_pkg;

	localparam int LINE_CAPACITY_DEF = 64;
	localparam int COMMAND_SLOTS_DEF = 8;

	// Command register file: eight 64-bit words of up to eight bytes each
	localparam int NUM_WORDS   = 8;
	localparam int WORD_BYTES  = 8;
	localparam int WORD_W      = 64;
	localparam int SLOT_W      = 3;
	localparam int CFG_INDEX_W = 4;
	// Line bytes held for matching: a full command plus the byte after it
	localparam int FETCH_BYTES = WORD_BYTES + 1;
	localparam int FETCH_W     = 4;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;

	localparam logic [1:0] STATUS_MATCHED  = 2'd0;
	localparam logic [1:0] STATUS_UNKNOWN  = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	function automatic logic is_blank(input logic [7:0] b);
		return (b inside {CH_SP, CH_TAB});
	endfunction

	// Count the bytes below the first zero byte of a command word
	function automatic logic [FETCH_W-1:0] word_length(input logic [WORD_W-1:0] w);
		logic [FETCH_W-1:0] n;
		logic stop;
		n = '0;
		stop = 1'b0;
		for (int i = 0; i < WORD_BYTES; i++) begin
			if (!stop && (w[i*8 +: 8] != 8'h00)) begin
				n = n + FETCH_W'(1);
			end else begin
				stop = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

// ===== rtl/command_line_assembler_matcher_top.sv =====
// Command line assembler and matcher: top level with control FSM and matcher.
// Depends on clam_pkg and clam_ram.
//
// Received bytes arrive on the rx channel one word at a time and build a line in a
// LINE_CAPACITY-entry byte RAM. Printable bytes and tab are stored, backspace and DEL
// drop the last stored byte, other control bytes are ignored, and a LF right after a CR
// is swallowed. A kept byte that would push the line past LINE_CAPACITY-1 bytes gives a
// single too-long result (status 2, last set) and the block then throws bytes away until
// the next CR or LF. On CR or LF the stored line is trimmed of leading and trailing
// spaces and tabs; a non-empty line is checked against the command words in slots
// 0..COMMAND_SLOTS-1 (longest match wins, lowest slot on a tie, and the command must be
// followed by end of line, space or tab), and then goes out byte by byte with status
// and command_index on every word and last on the final one.
// Flow: an ordinary byte leaves rx ready, even while a result waits on the output
// register. A CR or LF that ends a line keeps rx stalled while the line is trimmed
// and, if anything is left, matched and emitted, any output stall included; the line
// RAM's single read port sets this, since every trim step, the fetch of the first nine
// line bytes for matching and every emitted byte each need their own read. The RAM is
// only read while no byte is accepted, so reads and writes never meet on one entry.
// The RAM is not cleared after reset: only written entries are ever used. Command words
// are written on the cfg channel (index 0..7, higher indexes ignored), which is always
// ready, and must only change while the block is idle.
module command_line_assembler_matcher_top
	import clam_pkg::*;
#(
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
	parameter int COMMAND_SLOTS = COMMAND_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// received bytes
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             rx_byte,
	// result words
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic [2:0]             command_index,
	output logic [7:0]             line_byte,
	output logic                   last,
	// command word writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_data
);

	localparam int LW   = $clog2(LINE_CAPACITY);
	localparam int SW   = (COMMAND_SLOTS > 1) ? $clog2(COMMAND_SLOTS) : 1;
	localparam int SUMW = ((LW > FETCH_W) ? LW : FETCH_W) + 1;

	// controller states
	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_OVF       = 4'd1;
	localparam logic [3:0] S_LEAD      = 4'd2;
	localparam logic [3:0] S_LEAD_CHK  = 4'd3;
	localparam logic [3:0] S_TRAIL     = 4'd4;
	localparam logic [3:0] S_TRAIL_CHK = 4'd5;
	localparam logic [3:0] S_FETCH     = 4'd6;
	localparam logic [3:0] S_FWAIT     = 4'd7;
	localparam logic [3:0] S_MATCH     = 4'd8;
	localparam logic [3:0] S_EMIT      = 4'd9;
	localparam logic [3:0] S_EMIT_LOAD = 4'd10;

	logic [3:0]         state_q;
	logic [LW-1:0]      len_q;
	logic               discard_q;
	logic               last_cr_q;
	logic [LW-1:0]      start_q;
	logic [LW-1:0]      end_q;
	logic [LW-1:0]      ptr_q;
	logic [FETCH_W-1:0] fk_q;
	logic               cap_v_q;
	logic [FETCH_W-1:0] cap_idx_q;
	logic [7:0]         fbuf_q [FETCH_BYTES];
	logic [SW-1:0]      slot_q;
	logic [FETCH_W-1:0] best_len_q;
	logic [SLOT_W-1:0]  best_slot_q;
	logic [WORD_W-1:0]  cmd_q [NUM_WORDS];

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [2:0]         index_q;
	logic [7:0]         byte_q;
	logic               last_q;

	logic               in_fire;
	logic               out_free;
	logic               ram_we;
	logic               ram_re;
	logic [LW-1:0]      ram_raddr;
	logic [7:0]         ram_rdata;
	logic [SUMW-1:0]    fetch_sum;
	logic [LW-1:0]      fetch_addr;
	logic [SUMW-1:0]    tlen;
	logic [WORD_W-1:0]  cur_word;
	logic [FETCH_W-1:0] clen;
	logic               bytes_eq;
	logic               slot_hit;
	logic               keep_byte;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign command_index = index_q;
	assign line_byte     = byte_q;
	assign last          = last_q;

	// A byte is stored when it is not a line end, erase or stray control byte,
	// the block is not discarding and the line still has room.
	assign keep_byte = !discard_q && !(rx_byte inside {CH_CR, CH_LF, CH_BS, CH_DEL})
		&& !((rx_byte < CH_SP) && (rx_byte != CH_TAB))
		&& (len_q != LW'(LINE_CAPACITY - 1));
	assign ram_we = in_fire && keep_byte;

	// Fetch addresses past the trimmed end fall back to the first byte so that
	// only written entries are ever read.
	assign fetch_sum  = SUMW'(start_q) + SUMW'(fk_q);
	assign fetch_addr = (fetch_sum < SUMW'(end_q)) ? fetch_sum[LW-1:0] : start_q;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = start_q;
		case (state_q)
			S_LEAD: begin
				ram_re = (start_q != end_q);
			end
			S_TRAIL: begin
				ram_re    = 1'b1;
				ram_raddr = end_q - LW'(1);
			end
			S_FETCH: begin
				ram_re    = 1'b1;
				ram_raddr = fetch_addr;
			end
			S_EMIT: begin
				ram_re    = 1'b1;
				ram_raddr = ptr_q;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	clam_ram #(
		.WIDTH(8),
		.DEPTH(LINE_CAPACITY)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(len_q),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Match one slot per cycle against the buffered head of the line.
	assign tlen     = SUMW'(end_q) - SUMW'(start_q);
	assign cur_word = cmd_q[SLOT_W'(slot_q)];
	assign clen     = word_length(cur_word);

	always_comb begin
		bytes_eq = 1'b1;
		for (int i = 0; i < WORD_BYTES; i++) begin
			if ((FETCH_W'(i) < clen) && (fbuf_q[i] != cur_word[i*8 +: 8])) begin
				bytes_eq = 1'b0;
			end
		end
	end

	assign slot_hit = (clen > best_len_q) && (SUMW'(clen) <= tlen) && bytes_eq
		&& ((SUMW'(clen) == tlen) || is_blank(fbuf_q[clen]));

	// command word registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				cmd_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_INDEX_W'(NUM_WORDS))) begin
			cmd_q[cfg_index[SLOT_W-1:0]] <= cfg_data;
		end
	end

	// capture fetched line bytes in the cycle after their read
	always_ff @(posedge clk) begin
		if (cap_v_q) begin
			fbuf_q[cap_idx_q] <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			discard_q   <= 1'b0;
			last_cr_q   <= 1'b0;
			start_q     <= '0;
			end_q       <= '0;
			ptr_q       <= '0;
			fk_q        <= '0;
			cap_v_q     <= 1'b0;
			cap_idx_q   <= '0;
			slot_q      <= '0;
			best_len_q  <= '0;
			best_slot_q <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STATUS_MATCHED;
			index_q     <= '0;
			byte_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			cap_v_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if ((rx_byte == CH_LF) && last_cr_q) begin
							// drop the LF of a CR LF pair
							last_cr_q <= 1'b0;
						end else begin
							last_cr_q <= (rx_byte == CH_CR);
							if (rx_byte inside {CH_CR, CH_LF}) begin
								len_q <= '0;
								if (discard_q) begin
									discard_q <= 1'b0;
								end else begin
									start_q <= '0;
									end_q   <= len_q;
									state_q <= S_LEAD;
								end
							end else if (discard_q) begin
								discard_q <= 1'b1;
							end else if (rx_byte inside {CH_BS, CH_DEL}) begin
								if (len_q != '0) begin
									len_q <= len_q - LW'(1);
								end
							end else if ((rx_byte < CH_SP) && (rx_byte != CH_TAB)) begin
								discard_q <= 1'b0;
							end else if (len_q == LW'(LINE_CAPACITY - 1)) begin
								// overflow: clear the line and drop until line end
								discard_q <= 1'b1;
								len_q     <= '0;
								state_q   <= S_OVF;
							end else begin
								len_q <= len_q + LW'(1);
							end
						end
					end
				end
				S_OVF: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= STATUS_TOO_LONG;
						index_q     <= '0;
						byte_q      <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_LEAD: begin
					// an all-blank or empty line gives no result
					state_q <= (start_q == end_q) ? S_IDLE : S_LEAD_CHK;
				end
				S_LEAD_CHK: begin
					if (is_blank(ram_rdata)) begin
						start_q <= start_q + LW'(1);
						state_q <= S_LEAD;
					end else begin
						state_q <= S_TRAIL;
					end
				end
				S_TRAIL: begin
					state_q <= S_TRAIL_CHK;
				end
				S_TRAIL_CHK: begin
					// the first byte is not blank, so end never passes start
					if (is_blank(ram_rdata)) begin
						end_q   <= end_q - LW'(1);
						state_q <= S_TRAIL;
					end else begin
						fk_q        <= '0;
						slot_q      <= '0;
						best_len_q  <= '0;
						best_slot_q <= '0;
						state_q     <= S_FETCH;
					end
				end
				S_FETCH: begin
					cap_v_q   <= 1'b1;
					cap_idx_q <= fk_q;
					if (fk_q == FETCH_W'(FETCH_BYTES - 1)) begin
						state_q <= S_FWAIT;
					end else begin
						fk_q <= fk_q + FETCH_W'(1);
					end
				end
				S_FWAIT: begin
					state_q <= S_MATCH;
				end
				S_MATCH: begin
					if (slot_hit) begin
						best_len_q  <= clen;
						best_slot_q <= SLOT_W'(slot_q);
					end
					if (slot_q == SW'(COMMAND_SLOTS - 1)) begin
						ptr_q   <= start_q;
						state_q <= S_EMIT;
					end else begin
						slot_q <= slot_q + SW'(1);
					end
				end
				S_EMIT: begin
					state_q <= S_EMIT_LOAD;
				end
				S_EMIT_LOAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= (best_len_q != '0) ? STATUS_MATCHED : STATUS_UNKNOWN;
						index_q     <= (best_len_q != '0) ? best_slot_q : '0;
						byte_q      <= ram_rdata;
						last_q      <= ((ptr_q + LW'(1)) == end_q);
						ptr_q       <= ptr_q + LW'(1);
						state_q     <= ((ptr_q + LW'(1)) == end_q) ? S_IDLE : S_EMIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A too-long result is always a run of one word.
	a_too_long_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STATUS_TOO_LONG)) |-> (last && (line_byte == 8'h00)))
		else $error("too-long result without last or with nonzero byte");

	// The command index is only meaningful on a match.
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STATUS_MATCHED)) |-> (command_index == 3'd0))
		else $error("command index set without a match");

	// Trimming never moves the start of the line past its end.
	a_trim_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (start_q <= end_q))
		else $error("trimmed line start passed its end");

	// Every emitted word reaches the output, and rx stays stalled until the word with last is loaded.
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_LOAD && out_free) |=> (out_valid && !in_ready ||
			out_valid && last))
		else $error("emitted word lost or line ended without last");

endmodule

// ===== rtl/clam_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module clam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold the last read word while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== tb/command_line_assembler_matcher_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for command_line_assembler_matcher_top: line editing, trimming,
// command matching, overflow and discard, under random flow control on both channels.
// Depends on clam_pkg and the block's RTL only.
module command_line_assembler_matcher_top_tb
	import clam_pkg::*;
();

	localparam int CAPACITY      = LINE_CAPACITY_DEF;
	localparam int SLOTS         = COMMAND_SLOTS_DEF;
	// rx words to send over the whole run; the random lines fill up what is left
	localparam int TOTAL_ITEMS   = 160;
	// worst line close: one read per blank trimmed off, the slot scan and the emit walk
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT   = 1000000;

	// one result word as the block presents it
	typedef struct packed {
		logic [1:0] status;
		logic [2:0] index;
		logic [7:0] data;
		logic       last;
	} line_word_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   in_valid      = 1'b0;
	logic                   in_ready;
	logic [7:0]             rx_byte       = '0;
	logic                   out_valid;
	logic                   out_ready     = 1'b0;
	logic [1:0]             status;
	logic [2:0]             command_index;
	logic [7:0]             line_byte;
	logic                   last;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [WORD_W-1:0]      cfg_data      = '0;

	command_line_assembler_matcher_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.command_index (command_index),
		.line_byte     (line_byte),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Line predictor: our own copy of the line buffer, the editing flags
	// and the command table, advanced once per accepted rx word.
	// ------------------------------------------------------------------
	logic [7:0]        line_copy [CAPACITY];
	int unsigned       line_len     = 0;
	bit                dropping     = 1'b0;  // overflowed, throwing bytes away
	bit                after_cr     = 1'b0;
	logic [WORD_W-1:0] command_words [NUM_WORDS] = '{default: '0};
	logic [WORD_W-1:0] next_words    [NUM_WORDS] = '{default: '0};
	line_word_t        line_words [$];       // result words still owed by the block
	int                sent_items   = 0;     // rx words accepted by the block
	int                mismatches   = 0;
	int unsigned       cycle_count  = 0;

	// sender state
	int                burst_left   = 0;
	bit                rx_held      = 1'b0;  // in_valid still high from the last word

	// receiver stall pattern
	logic [7:0]        ready_pattern = 8'hFF;
	int                pattern_left  = 0;

	function automatic bit blank(input logic [7:0] b);
		return (b == CH_SP) || (b == CH_TAB);
	endfunction

	// bytes below the first zero byte of a command word
	function automatic int unsigned command_length(input logic [WORD_W-1:0] w);
		int unsigned n;
		n = 0;
		while (n < WORD_BYTES && w[n*8 +: 8] != 8'h00) begin
			n++;
		end
		return n;
	endfunction

	// Trim the buffered line, pick the longest command (lowest slot on a tie) and
	// queue one result word per trimmed byte.
	function automatic void close_line();
		int unsigned first;
		int unsigned stop;
		int unsigned tlen;
		int unsigned clen;
		int unsigned best_len;
		logic [2:0]  best_slot;
		bit          hit;
		bit          ok;
		line_word_t  w;
		first = 0;
		stop = line_len;
		while (first < stop && blank(line_copy[first])) begin
			first++;
		end
		while (stop > first && blank(line_copy[stop-1])) begin
			stop--;
		end
		if (first != stop) begin
			tlen = stop - first;
			best_len = 0;
			best_slot = '0;
			hit = 1'b0;
			for (int s = 0; s < SLOTS; s++) begin
				clen = command_length(command_words[s]);
				if (clen > best_len && clen <= tlen) begin
					ok = 1'b1;
					for (int i = 0; i < clen; i++) begin
						if (line_copy[first+i] != command_words[s][i*8 +: 8]) begin
							ok = 1'b0;
						end
					end
					// the command has to end at a word boundary of the line
					if (ok && clen < tlen && !blank(line_copy[first+clen])) begin
						ok = 1'b0;
					end
					if (ok) begin
						hit = 1'b1;
						best_len = clen;
						best_slot = 3'(s);
					end
				end
			end
			for (int unsigned i = 0; i < tlen; i++) begin
				w.status = hit ? STATUS_MATCHED : STATUS_UNKNOWN;
				w.index  = hit ? best_slot : 3'd0;
				w.data   = line_copy[first+i];
				w.last   = (i + 1 == tlen);
				line_words.push_back(w);
			end
		end
		line_len = 0;
	endfunction

	function automatic void track_rx_byte(input logic [7:0] b);
		line_word_t w;
		// swallow the LF of a CR LF pair
		if (b == CH_LF && after_cr) begin
			after_cr = 1'b0;
			return;
		end
		after_cr = (b == CH_CR);
		if (b == CH_CR || b == CH_LF) begin
			if (dropping) begin
				dropping = 1'b0;
				line_len = 0;
			end else begin
				close_line();
			end
			return;
		end
		if (dropping) begin
			return;
		end
		if (b == CH_BS || b == CH_DEL) begin
			if (line_len != 0) begin
				line_len--;
			end
			return;
		end
		if (b < CH_SP && b != CH_TAB) begin
			return;
		end
		if (line_len >= CAPACITY - 1) begin
			// overflow: one too-long word, then discard up to the line end
			dropping = 1'b1;
			line_len = 0;
			w.status = STATUS_TOO_LONG;
			w.index  = 3'd0;
			w.data   = 8'h00;
			w.last   = 1'b1;
			line_words.push_back(w);
			return;
		end
		line_copy[line_len] = b;
		line_len++;
	endfunction

	// ------------------------------------------------------------------
	// Result checker: every accepted output word against the oldest
	// expectation.
	// ------------------------------------------------------------------
	function automatic void report_word(input string why, input line_word_t want,
			input line_word_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected status %0d index %0d byte %02h last %0d,",
				$time, why, want.status, want.index, want.data, want.last);
			$display("    got status %0d index %0d byte %02h last %0d",
				got.status, got.index, got.data, got.last);
		end
	endfunction

	always @(posedge clk) begin : result_check
		line_word_t got;
		line_word_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {status, command_index, line_byte, last};
			if (line_words.size() == 0) begin
				report_word("result word with nothing expected", '0, got);
			end else begin
				want = line_words.pop_front();
				if (got !== want) begin
					report_word("result word mismatch", want, got);
				end
			end
		end
	end

	// Receiver: rotate an 8-bit ready pattern, reload it once a random rotation count runs out.
	// All-ones stretches give runs without stalls; any other pattern has at least one ready bit.
	always @(posedge clk) begin
		if (pattern_left == 0) begin
			pattern_left <= $urandom_range(16, 80);
			if ($urandom_range(0, 3) == 0) begin
				ready_pattern <= 8'hFF;
			end else begin
				ready_pattern <= 8'($urandom) | 8'h01;
			end
		end else begin
			pattern_left <= pattern_left - 1;
			ready_pattern <= {ready_pattern[6:0], ready_pattern[7]};
		end
		out_ready <= ready_pattern[0];
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("command_line_assembler_matcher_top_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// drop in_valid once the last word is gone and nothing follows at once
	task automatic rx_idle();
		if (rx_held) begin
			in_valid <= 1'b0;
			rx_held = 1'b0;
		end
	endtask

	// Offer one rx word and hold it until accepted. Bursts of back-to-back words
	// alternate with short gaps.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(1, 8);
			rx_idle();
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		rx_byte  <= b;
		in_valid <= 1'b1;
		rx_held = 1'b1;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		sent_items++;
		track_rx_byte(b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	// hold the sender until every owed result word has come out
	task automatic wait_drain();
		rx_idle();
		while (line_words.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// drained, and the block done with any line close that gives no word
	task automatic settle_idle();
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all command slots from next_words, then one write to an index past
	// the table, which the block has to ignore.
	task automatic load_commands();
		logic [CFG_INDEX_W-1:0] idx;
		logic [WORD_W-1:0]      data;
		settle_idle();
		for (int i = 0; i <= NUM_WORDS; i++) begin
			if (i < NUM_WORDS) begin
				idx  = CFG_INDEX_W'(i);
				data = next_words[i];
			end else begin
				idx  = CFG_INDEX_W'($urandom_range(NUM_WORDS, (1 << CFG_INDEX_W) - 1));
				data = {$urandom, $urandom};
			end
			cfg_index <= idx;
			cfg_data  <= data;
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready) begin
				@(posedge clk);
			end
			if (idx < NUM_WORDS) begin
				command_words[idx] = data;
			end
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] text_word(input string s);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < s.len() && i < WORD_BYTES; i++) begin
			w[i*8 +: 8] = s[i];
		end
		return w;
	endfunction

	// short commands over a three-letter alphabet, so prefixes overlap a lot
	function automatic logic [WORD_W-1:0] letter_word();
		logic [WORD_W-1:0] w;
		int                n;
		w = '0;
		n = $urandom_range(1, WORD_BYTES);
		for (int i = 0; i < n; i++) begin
			w[i*8 +: 8] = 8'($urandom_range(8'h61, 8'h63));
		end
		// junk past the terminating zero must not count
		if (n < WORD_BYTES - 1 && $urandom_range(0, 3) == 0) begin
			w[(n+1)*8 +: 8] = 8'($urandom_range(8'h61, 8'h63));
		end
		return w;
	endfunction

	function automatic logic [7:0] random_blank();
		return $urandom_range(0, 1) ? CH_SP : CH_TAB;
	endfunction

	function automatic logic [7:0] random_arg();
		if ($urandom_range(0, 4) == 0) begin
			return 8'($urandom_range(8'h20, 8'hFF));
		end
		return 8'($urandom_range(8'h61, 8'h64));
	endfunction

	// One line: mostly a command with arguments, sometimes noise or a long line.
	task automatic send_random_line();
		int          kind;
		int          s;
		int unsigned clen;
		kind = $urandom_range(0, 39);
		if (kind == 0) begin
			repeat ($urandom_range(CAPACITY - 4, CAPACITY + 4)) begin
				send_byte(8'($urandom_range(8'h21, 8'h7E)));
			end
		end else if (kind < 7) begin
			repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
		end else begin
			repeat ($urandom_range(0, 2)) send_byte(random_blank());
			s = $urandom_range(0, NUM_WORDS - 1);
			clen = command_length(command_words[s]);
			if (clen > 1 && $urandom_range(0, 5) == 0) begin
				clen--;
			end
			for (int i = 0; i < clen; i++) begin
				send_byte(command_words[s][i*8 +: 8]);
			end
			case ($urandom_range(0, 3))
				0: ;
				1: send_byte(8'($urandom_range(8'h61, 8'h63)));
				default: begin
					send_byte(random_blank());
					repeat ($urandom_range(0, 4)) send_byte(random_arg());
				end
			endcase
			if ($urandom_range(0, 4) == 0) begin
				send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
			end
			if ($urandom_range(0, 5) == 0) begin
				send_byte(8'($urandom_range(8'h00, 8'h1F)));
			end
			repeat ($urandom_range(0, 2)) send_byte(random_blank());
		end
		case ($urandom_range(0, 3))
			0: send_byte(CH_CR);
			1: send_byte(CH_LF);
			2: begin
				send_byte(CH_CR);
				send_byte(CH_LF);
			end
			default: begin
				send_byte(CH_LF);
				send_byte(CH_CR);
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Table as reset leaves it: no slot in use, every line is unknown.
	task automatic test_empty_table();
		send_text("ab\r");
	endtask

	task automatic test_directed_cases();
		next_words[0] = text_word("ab");
		next_words[1] = text_word("abc");
		next_words[2] = text_word("abc");
		next_words[3] = '0;
		next_words[4] = text_word("x");
		next_words[5] = text_word("ab") | (text_word("zz") << 24);
		next_words[6] = text_word("abcdefgh");
		next_words[7] = text_word("q");
		load_commands();
		// leading blank, longest prefix ended by a tab, tie on slots 1 and 2
		send_text(" abc\td\r");
		// LF of the CR LF pair is swallowed
		send_byte(CH_LF);
		// erase on an empty line, then erase down to empty again
		send_byte(CH_DEL);
		send_text("ab");
		send_byte(CH_BS);
		send_byte(CH_DEL);
		send_text("x\n");
		// dropped control bytes; the three-letter command is longer than the line
		send_byte(8'h00);
		send_text("ab");
		send_byte(8'h1F);
		send_byte(CH_CR);
		// high bytes, no command
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(CH_LF);
		// blank line gives nothing
		send_text(" \t\r");
	endtask

	// All slots full of 0xFF bytes: eight-byte commands, always a tie.
	task automatic test_full_words();
		for (int s = 0; s < NUM_WORDS; s++) begin
			next_words[s] = '1;
		end
		load_commands();
		repeat (WORD_BYTES) send_byte(8'hFF);
		send_text(" a\r");
		repeat (WORD_BYTES + 1) send_byte(8'hFF);
		send_byte(CH_CR);
		send_byte(CH_TAB);
		repeat (WORD_BYTES) send_byte(8'hFF);
		send_text("\t\n");
	endtask

	// A line filled to capacity, then one byte too many, the discard and its end.
	task automatic test_line_capacity();
		repeat (CAPACITY - 1) send_byte(8'($urandom_range(8'h21, 8'h7E)));
		send_byte(8'($urandom_range(8'h21, 8'h7E)));
		// ignored while discarding, erase included
		send_text("ab");
		send_byte(CH_BS);
		// CR ends the discard; its LF is still swallowed
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_text("q\r");
	endtask

	// Random lines over several command tables: overlapping letter commands,
	// tables with unused slots, and fully random 64-bit words.
	task automatic test_random_lines();
		int goal;
		for (int phase = 0; phase < 4; phase++) begin
			for (int s = 0; s < NUM_WORDS; s++) begin
				if (phase == 2) begin
					next_words[s] = {$urandom, $urandom};
				end else if (phase == 1 && $urandom_range(0, 2) == 0) begin
					next_words[s] = '0;
				end else begin
					next_words[s] = letter_word();
				end
			end
			load_commands();
			// spread what is left of the word budget over the remaining tables
			goal = sent_items + (TOTAL_ITEMS - sent_items) / (4 - phase);
			if (goal <= sent_items) begin
				goal = sent_items + 1;
			end
			while (sent_items < goal) begin
				send_random_line();
				// now and then hold off until the block has caught up
				if ($urandom_range(0, 7) == 0) begin
					wait_drain();
				end
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed_cases();
		test_full_words();
		test_line_capacity();
		test_random_lines();
		settle_idle();
		if (line_words.size() != 0) begin
			$display("%0d result words never arrived", line_words.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("command_line_assembler_matcher_top_tb OK");
		end else begin
			$display("command_line_assembler_matcher_top_tb NOT OK");
		end
		$finish;
	end

endmodule
